// ===== hw/rtl/fbi_pkg.sv =====
// Shared types and constants of the face box interpolator.
// Holds the request/response beat structs, function, source and status codes.
// No dependencies.
package fbi_pkg;

   localparam int unsigned MAX_FRAMES_DEF = 64;
   localparam int unsigned MAX_BOXES_DEF  = 8;

   // function codes
   localparam logic [1:0] FUNC_CLEAR = 2'd0;
   localparam logic [1:0] FUNC_STORE = 2'd1;
   localparam logic [1:0] FUNC_QUERY = 2'd2;

   // result source codes
   localparam logic [2:0] SRC_EXACT  = 3'd0;
   localparam logic [2:0] SRC_EARLY  = 3'd1;
   localparam logic [2:0] SRC_LATE   = 3'd2;
   localparam logic [2:0] SRC_INTERP = 3'd3;
   localparam logic [2:0] SRC_NONE   = 3'd4;

   // status codes
   localparam logic [1:0] STAT_OK          = 2'd0;
   localparam logic [1:0] STAT_FRAMES_FULL = 2'd1;
   localparam logic [1:0] STAT_LIST_FULL   = 2'd2;

   // register indexes and reset values
   localparam logic CSR_STEP   = 1'b0;
   localparam logic CSR_RADIUS = 1'b1;
   localparam logic [15:0] STEP_RST   = 16'd5;
   localparam logic [14:0] RADIUS_RST = 15'd3277;

   // divider widths: dividend 2*|d|*num + den, divisor 2*den
   localparam int unsigned DIV_N_W = 36;
   localparam int unsigned DIV_D_W = 19;

   typedef struct packed {
      logic [1:0]         func;
      logic [23:0]        position;
      logic               first_box;
      logic               has_box;
      logic signed [15:0] box_x;
      logic signed [15:0] box_y;
      logic signed [15:0] box_w;
      logic signed [15:0] box_h;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               box_found;
      logic [2:0]         source;
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic signed [15:0] out_w;
      logic signed [15:0] out_h;
      logic               last;
   } rsp_type;

endpackage

// ===== hw/rtl/fbi_div.sv =====
// Restoring divider, one quotient bit per cycle, for the interpolation step.
// Depends on fbi_pkg for the operand widths.
module fbi_div
   import fbi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_N_W-1:0] dividend,
   input  logic [DIV_D_W-1:0] divisor,
   output logic               done,
   output logic [DIV_N_W-1:0] quotient
);

   localparam int unsigned CNT_W = $clog2(DIV_N_W + 1);

   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [DIV_N_W-1:0] quo_ff;
   logic [DIV_D_W-1:0] rem_ff;
   logic [DIV_D_W:0]   trial;
   logic               ge;

   // shift in next dividend bit and try a subtract
   assign trial = {rem_ff, quo_ff[DIV_N_W-1]};
   assign ge    = trial >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIV_N_W);
            quo_ff  <= dividend;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= ge ? DIV_D_W'(trial - {1'b0, divisor}) : trial[DIV_D_W-1:0];
            quo_ff <= {quo_ff[DIV_N_W-2:0], ge};
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hw/rtl/face_box_interpolator_top.sv =====
// Face box interpolator: per-frame face box store with interpolating query.
// Every item first scans all MAX_FRAMES slots of the frame memory;
// clear and store then finish in the decide state. A query then reads out each
// box of a matched list, or pairs each earlier box with the nearest later box
// and runs the divider once per coordinate of a paired box.
// One item at a time; busy is high until its last result beat. The receiver
// cannot stall. Synchronous reset clears valid bits and write slot and loads the register reset values.
module face_box_interpolator_top
   import fbi_pkg::*;
#(
   parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF,
   parameter int unsigned MAX_BOXES  = MAX_BOXES_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_start,
   output logic        req_busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned SW = $clog2(MAX_FRAMES);
   localparam int unsigned CW = $clog2(MAX_BOXES + 1);
   localparam int unsigned IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int unsigned BA = $clog2(MAX_FRAMES * MAX_BOXES);
   localparam int unsigned FW = 24 + CW;

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_SCAN   = 5'd1;
   localparam logic [4:0] ST_DECIDE = 5'd2;
   localparam logic [4:0] ST_LRD    = 5'd3;
   localparam logic [4:0] ST_LOUT   = 5'd4;
   localparam logic [4:0] ST_FRD    = 5'd5;
   localparam logic [4:0] ST_FGET   = 5'd6;
   localparam logic [4:0] ST_CRD    = 5'd7;
   localparam logic [4:0] ST_CDIFF  = 5'd8;
   localparam logic [4:0] ST_CSQ    = 5'd9;
   localparam logic [4:0] ST_CCMP   = 5'd10;
   localparam logic [4:0] ST_IRES   = 5'd11;
   localparam logic [4:0] ST_MUL    = 5'd12;
   localparam logic [4:0] ST_DSTART = 5'd13;
   localparam logic [4:0] ST_DWAIT  = 5'd14;
   localparam logic [4:0] ST_IOUT   = 5'd15;

   function automatic logic [BA-1:0] baddr(input logic [SW-1:0] s, input logic [IW-1:0] i);
      baddr = BA'(s) * BA'(MAX_BOXES) + BA'(i);
   endfunction

   // doubled box center: 2*a + b
   function automatic logic signed [17:0] centre(input logic [15:0] a, input logic [15:0] b);
      centre = $signed({a[15], a, 1'b0}) + $signed({{2{b[15]}}, b});
   endfunction

   // memories
   logic [FW-1:0] frame_mem [MAX_FRAMES];
   logic [63:0]   box_mem   [MAX_FRAMES * MAX_BOXES];
   logic [FW-1:0] frame_rd_ff;
   logic [63:0]   box_rd_ff;
   logic          frame_we, box_we;
   logic [SW-1:0] frame_waddr;
   logic [FW-1:0] frame_wdata;
   logic [BA-1:0] box_waddr, box_raddr;
   logic [63:0]   box_wdata;

   // control and working registers
   logic [4:0]            state_ff;
   req_type               req_ff;
   logic [SW:0]           scan_ff;
   logic [MAX_FRAMES-1:0] valid_ff;
   logic [SW-1:0]         wslot_ff;
   logic [15:0]           step_ff;
   logic [14:0]           radius_ff;
   logic                  hit_ff, bs_ok_ff, as_ok_ff;
   logic [SW-1:0]         hit_slot_ff, bs_slot_ff, as_slot_ff, lslot_ff;
   logic [CW-1:0]         hit_cnt_ff, bs_cnt_ff, as_cnt_ff, lcnt_ff;
   logic [23:0]           bs_pos_ff, as_pos_ff;
   logic [2:0]            lsrc_ff;
   logic [CW-1:0]         idx_ff, jdx_ff;
   logic [17:0]           num_ff, den_ff;
   logic [31:0]           lim_ff;
   logic [63:0]           f_ff, c_ff, t_ff, res_ff;
   logic signed [18:0]    dx_ff, dy_ff;
   logic [35:0]           sqx_ff, sqy_ff;
   logic [36:0]           best_ff;
   logic                  match_ff;
   logic [1:0]            k_ff;
   logic                  neg_ff;
   logic [33:0]           prod_ff;
   logic                  rsp_strobe_ff;
   rsp_type               rsp_ff;

   // scan pipeline view of the entry read last cycle
   logic [SW:0]   scan_m1;
   logic [SW-1:0] pslot;
   logic [23:0]   fpos;
   logic [CW-1:0] fcnt;
   logic          fvalid;
   assign scan_m1 = scan_ff - (SW+1)'(1);
   assign pslot   = scan_m1[SW-1:0];
   assign fpos    = frame_rd_ff[FW-1:CW];
   assign fcnt    = frame_rd_ff[CW-1:0];
   assign fvalid  = valid_ff[pslot];

   // store decision
   logic [CW-1:0] st_base_cnt, st_new_cnt;
   logic [SW-1:0] st_slot;
   logic          st_ok, st_full, st_add;
   logic [1:0]    st_status;
   always_comb begin
      st_base_cnt = (hit_ff && !req_ff.first_box) ? hit_cnt_ff : '0;
      st_slot     = hit_ff ? hit_slot_ff : wslot_ff;
      st_ok       = hit_ff || !valid_ff[wslot_ff];
      st_full     = st_base_cnt >= CW'(MAX_BOXES);
      st_add      = st_ok && req_ff.has_box && !st_full;
      st_new_cnt  = st_add ? st_base_cnt + CW'(1) : st_base_cnt;
      if (!st_ok) begin
         st_status = STAT_FRAMES_FULL;
      end else if (req_ff.has_box && st_full) begin
         st_status = STAT_LIST_FULL;
      end else begin
         st_status = STAT_OK;
      end
   end

   // query decision
   logic [23:0]   gap_after, gap_before, span;
   logic [17:0]   step3;
   logic          qm_list, qm_interp;
   logic [SW-1:0] ql_slot;
   logic [CW-1:0] ql_cnt;
   logic [2:0]    ql_src;
   always_comb begin
      gap_after  = as_pos_ff - req_ff.position;
      gap_before = req_ff.position - bs_pos_ff;
      span       = as_pos_ff - bs_pos_ff;
      step3      = {2'b00, step_ff} + {1'b0, step_ff, 1'b0};
      qm_list    = 1'b0;
      qm_interp  = 1'b0;
      ql_slot    = hit_slot_ff;
      ql_cnt     = hit_cnt_ff;
      ql_src     = SRC_EXACT;
      if (hit_ff) begin
         qm_list = 1'b1;
      end else if (!bs_ok_ff && !as_ok_ff) begin
         qm_list = 1'b0;
      end else if (!bs_ok_ff) begin
         qm_list = gap_after <= 24'(step_ff);
         ql_slot = as_slot_ff;
         ql_cnt  = as_cnt_ff;
         ql_src  = SRC_LATE;
      end else if (!as_ok_ff || span > 24'(step3)) begin
         qm_list = gap_before <= 24'(step_ff);
         ql_slot = bs_slot_ff;
         ql_cnt  = bs_cnt_ff;
         ql_src  = SRC_EARLY;
      end else begin
         qm_interp = 1'b1;
      end
   end

   // interpolation datapath pieces
   logic [15:0]        la, lb;
   logic signed [16:0] ld, nld;
   logic [15:0]        lmag;
   logic [18:0]        ndx, ndy;
   logic [17:0]        mdx, mdy;
   logic [36:0]        dsum;
   logic [DIV_N_W-1:0] div_q;
   logic               div_done, div_start;
   logic [15:0]        lres;
   always_comb begin
      la   = f_ff[16*k_ff +: 16];
      lb   = t_ff[16*k_ff +: 16];
      ld   = $signed({lb[15], lb}) - $signed({la[15], la});
      nld  = -ld;
      lmag = ld[16] ? nld[15:0] : ld[15:0];
      ndx  = -dx_ff;
      ndy  = -dy_ff;
      mdx  = dx_ff[18] ? ndx[17:0] : dx_ff[17:0];
      mdy  = dy_ff[18] ? ndy[17:0] : dy_ff[17:0];
      dsum = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      lres = neg_ff ? la - div_q[15:0] : la + div_q[15:0];
   end
   assign div_start = state_ff == ST_DSTART;

   fbi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({prod_ff, 1'b0} + DIV_N_W'(den_ff)),
      .divisor  ({den_ff, 1'b0}),
      .done     (div_done),
      .quotient (div_q)
   );

   // result beat selection
   logic    emit_v;
   rsp_type emit_rsp;
   logic    last_l, last_i;
   assign last_l = (idx_ff + CW'(1)) == lcnt_ff;
   assign last_i = (idx_ff + CW'(1)) == bs_cnt_ff;
   always_comb begin
      emit_v              = 1'b0;
      emit_rsp            = '0;
      emit_rsp.source     = SRC_NONE;
      emit_rsp.last       = 1'b1;
      case (state_ff)
         ST_DECIDE: begin
            emit_v = !(req_ff.func == FUNC_QUERY &&
                       ((qm_list && ql_cnt != '0) || (qm_interp && bs_cnt_ff != '0)));
            if (req_ff.func == FUNC_STORE) begin
               emit_rsp.status = st_status;
            end
            if (req_ff.func == FUNC_QUERY) begin
               emit_rsp.source = qm_list ? ql_src : (qm_interp ? SRC_INTERP : SRC_NONE);
            end
         end
         ST_LOUT: begin
            emit_v             = 1'b1;
            emit_rsp.box_found = 1'b1;
            emit_rsp.source    = lsrc_ff;
            emit_rsp.out_x     = box_rd_ff[15:0];
            emit_rsp.out_y     = box_rd_ff[31:16];
            emit_rsp.out_w     = box_rd_ff[47:32];
            emit_rsp.out_h     = box_rd_ff[63:48];
            emit_rsp.last      = last_l;
         end
         ST_IRES, ST_IOUT: begin
            emit_v             = (state_ff == ST_IOUT) || !match_ff;
            emit_rsp.box_found = 1'b1;
            emit_rsp.source    = SRC_INTERP;
            emit_rsp.out_x     = (state_ff == ST_IOUT) ? res_ff[15:0]  : f_ff[15:0];
            emit_rsp.out_y     = (state_ff == ST_IOUT) ? res_ff[31:16] : f_ff[31:16];
            emit_rsp.out_w     = (state_ff == ST_IOUT) ? res_ff[47:32] : f_ff[47:32];
            emit_rsp.out_h     = (state_ff == ST_IOUT) ? res_ff[63:48] : f_ff[63:48];
            emit_rsp.last      = last_i;
         end
         default: begin
            emit_v = 1'b0;
         end
      endcase
   end

   // memory write and read ports
   always_comb begin
      frame_we    = state_ff == ST_DECIDE && req_ff.func == FUNC_STORE && st_ok;
      frame_waddr = st_slot;
      frame_wdata = {req_ff.position, st_new_cnt};
      box_we      = state_ff == ST_DECIDE && req_ff.func == FUNC_STORE && st_add;
      box_waddr   = baddr(st_slot, st_base_cnt[IW-1:0]);
      box_wdata   = {req_ff.box_h, req_ff.box_w, req_ff.box_y, req_ff.box_x};
      case (state_ff)
         ST_LRD:  box_raddr = baddr(lslot_ff, idx_ff[IW-1:0]);
         ST_FRD:  box_raddr = baddr(bs_slot_ff, idx_ff[IW-1:0]);
         ST_CRD:  box_raddr = baddr(as_slot_ff, jdx_ff[IW-1:0]);
         default: box_raddr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_mem[frame_waddr] <= frame_wdata;
      end
      frame_rd_ff <= frame_mem[scan_ff[SW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (box_we) begin
         box_mem[box_waddr] <= box_wdata;
      end
      box_rd_ff <= box_mem[box_raddr];
   end

   // main sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         wslot_ff      <= '0;
         step_ff       <= STEP_RST;
         radius_ff     <= RADIUS_RST;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= emit_v;
         if (emit_v) begin
            rsp_ff <= emit_rsp;
         end

         // register writes
         if (csr_psel && csr_penable && csr_pwrite) begin
            if (csr_paddr[2] == CSR_STEP) begin
               step_ff <= csr_pwdata[15:0];
            end else begin
               radius_ff <= csr_pwdata[14:0];
            end
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_start) begin
                  req_ff   <= req_data;
                  scan_ff  <= '0;
                  hit_ff   <= 1'b0;
                  bs_ok_ff <= 1'b0;
                  as_ok_ff <= 1'b0;
                  state_ff <= ST_SCAN;
               end
            end
            // find exact, nearest earlier and nearest later frame
            ST_SCAN: begin
               scan_ff <= scan_ff + (SW+1)'(1);
               if (scan_ff != '0 && fvalid) begin
                  if (fpos == req_ff.position) begin
                     hit_ff      <= 1'b1;
                     hit_slot_ff <= pslot;
                     hit_cnt_ff  <= fcnt;
                  end
                  if (fpos < req_ff.position && (!bs_ok_ff || fpos > bs_pos_ff)) begin
                     bs_ok_ff   <= 1'b1;
                     bs_slot_ff <= pslot;
                     bs_pos_ff  <= fpos;
                     bs_cnt_ff  <= fcnt;
                  end
                  if (fpos > req_ff.position && (!as_ok_ff || fpos < as_pos_ff)) begin
                     as_ok_ff   <= 1'b1;
                     as_slot_ff <= pslot;
                     as_pos_ff  <= fpos;
                     as_cnt_ff  <= fcnt;
                  end
               end
               if (scan_ff == (SW+1)'(MAX_FRAMES)) begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               state_ff <= ST_IDLE;
               idx_ff   <= '0;
               case (req_ff.func)
                  FUNC_CLEAR: begin
                     valid_ff <= '0;
                     wslot_ff <= '0;
                  end
                  FUNC_STORE: begin
                     if (st_ok && !hit_ff) begin
                        valid_ff[wslot_ff] <= 1'b1;
                        wslot_ff <= (wslot_ff == SW'(MAX_FRAMES - 1)) ? '0
                                                                     : wslot_ff + SW'(1);
                     end
                  end
                  FUNC_QUERY: begin
                     lslot_ff <= ql_slot;
                     lcnt_ff  <= ql_cnt;
                     lsrc_ff  <= ql_src;
                     num_ff   <= gap_before[17:0];
                     den_ff   <= span[17:0];
                     lim_ff   <= {30'(radius_ff) * 30'(radius_ff), 2'b00};
                     if (qm_list && ql_cnt != '0) begin
                        state_ff <= ST_LRD;
                     end else if (qm_interp && bs_cnt_ff != '0) begin
                        state_ff <= ST_FRD;
                     end
                  end
                  default: begin
                     state_ff <= ST_IDLE;
                  end
               endcase
            end
            // return a stored list
            ST_LRD: begin
               state_ff <= ST_LOUT;
            end
            ST_LOUT: begin
               idx_ff   <= idx_ff + CW'(1);
               state_ff <= last_l ? ST_IDLE : ST_LRD;
            end
            // pair each earlier box with the nearest later box
            ST_FRD: begin
               state_ff <= ST_FGET;
            end
            ST_FGET: begin
               f_ff     <= box_rd_ff;
               best_ff  <= {5'b0, lim_ff};
               match_ff <= 1'b0;
               jdx_ff   <= '0;
               state_ff <= (as_cnt_ff == '0) ? ST_IRES : ST_CRD;
            end
            ST_CRD: begin
               state_ff <= ST_CDIFF;
            end
            ST_CDIFF: begin
               c_ff     <= box_rd_ff;
               dx_ff    <= 19'(centre(box_rd_ff[15:0], box_rd_ff[47:32]))
                         - 19'(centre(f_ff[15:0], f_ff[47:32]));
               dy_ff    <= 19'(centre(box_rd_ff[31:16], box_rd_ff[63:48]))
                         - 19'(centre(f_ff[31:16], f_ff[63:48]));
               state_ff <= ST_CSQ;
            end
            ST_CSQ: begin
               sqx_ff   <= mdx * mdx;
               sqy_ff   <= mdy * mdy;
               state_ff <= ST_CCMP;
            end
            ST_CCMP: begin
               if (dsum < best_ff) begin
                  best_ff  <= dsum;
                  match_ff <= 1'b1;
                  t_ff     <= c_ff;
               end
               jdx_ff   <= jdx_ff + CW'(1);
               state_ff <= ((jdx_ff + CW'(1)) == as_cnt_ff) ? ST_IRES : ST_CRD;
            end
            ST_IRES: begin
               k_ff <= '0;
               if (match_ff) begin
                  state_ff <= ST_MUL;
               end else begin
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= last_i ? ST_IDLE : ST_FRD;
               end
            end
            // linear step per coordinate, rounded half away from zero
            ST_MUL: begin
               neg_ff   <= ld[16];
               prod_ff  <= lmag * num_ff;
               state_ff <= ST_DSTART;
            end
            ST_DSTART: begin
               state_ff <= ST_DWAIT;
            end
            ST_DWAIT: begin
               if (div_done) begin
                  res_ff[16*k_ff +: 16] <= lres;
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= (k_ff == 2'd3) ? ST_IOUT : ST_MUL;
               end
            end
            ST_IOUT: begin
               idx_ff   <= idx_ff + CW'(1);
               state_ff <= last_i ? ST_IDLE : ST_FRD;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_busy   = state_ff != ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_STEP) ? {16'b0, step_ff} : {17'b0, radius_ff};

endmodule
